### rtl/bsr_pkg.sv
// bsr_pkg: request/response types, op and status codes and the
// controller command struct for the bitstream reader
// no dependencies

package bsr_pkg;

    // request op codes
    localparam logic [2:0] OP_CLEAR  = 3'd0;
    localparam logic [2:0] OP_APPEND = 3'd1;
    localparam logic [2:0] OP_PEEK   = 3'd2;
    localparam logic [2:0] OP_READ   = 3'd3;
    localparam logic [2:0] OP_SKIP   = 3'd4;
    localparam logic [2:0] OP_REWIND = 3'd5;

    // response status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_OVERRUN = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;

    // widest field a peek or read returns
    localparam int MAX_FETCH = 32;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  data_byte;
        logic [15:0] bit_count;
    } bsr_req_t;

    typedef struct packed {
        logic [31:0] value;
        logic [15:0] bits_remaining;
        logic [15:0] bits_consumed;
        logic        byte_aligned;
        logic        trailing_only;
        logic        more_data;
        logic [1:0]  status;
    } bsr_rsp_t;

    typedef struct packed {
        logic capture;   // take the request, start the bank reads
        logic commit;    // update reader state, load the response register
    } bsr_cmd_t;

endpackage

### rtl/bsr_ctrl.sv
// bsr_ctrl: two-state controller for the bitstream reader, owns the
// handshakes and the response valid flag
// depends on bsr_pkg

module bsr_ctrl
    import bsr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output bsr_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;

    assign req_ready   = (state_reg == ST_IDLE);
    assign cmd.capture = req_valid && req_ready;
    // finish only when the response register is free or being emptied
    assign cmd.commit  = (state_reg == ST_EXEC) && (!rsp_valid_reg || rsp_ready);
    assign rsp_valid   = rsp_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (cmd.commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp_valid_next = cmd.commit || (rsp_valid_reg && !rsp_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

### rtl/bsr_datapath.sv
// bsr_datapath: byte store in eight banks, reader position and count,
// last-one tracking, field extraction and the response register
// depends on bsr_pkg

module bsr_datapath
    import bsr_pkg::*;
#(
    parameter int BUFFER_BYTES = 4096
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  bsr_cmd_t cmd,
    input  bsr_req_t req,
    output bsr_rsp_t rsp
);

    localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
    localparam int BIT_W = CNT_W + 3;
    localparam int LO_W  = $clog2(BUFFER_BYTES * 8);
    localparam int ROWS  = (BUFFER_BYTES + 7) / 8;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int RA_W  = ROW_W + 1;
    localparam int WW    = (BIT_W > 16) ? BIT_W : 16;

    bsr_req_t         item_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [BIT_W-1:0] pos_reg;
    logic [BIT_W-1:0] pos_next;
    logic [LO_W-1:0]  lo_pos_reg;
    logic [LO_W-1:0]  lo_pos_next;
    logic             lo_valid_reg;
    logic             lo_valid_next;
    bsr_rsp_t         rsp_reg;
    bsr_rsp_t         rsp_next;

    logic [7:0]       bank_q [8];

    // ---------------- bank reads, issued at capture from the current position
    // bytes b..b+4 sit in banks (b+k)&7; banks below b&7 come from the next row
    logic [CNT_W-1:0] base_byte;
    logic [RA_W-1:0]  base_row;
    logic [2:0]       base_bank;
    logic             wr_en;
    logic [2:0]       wr_bank;
    logic [ROW_W-1:0] wr_row;

    assign base_byte = pos_reg[BIT_W-1:3];
    assign base_row  = RA_W'(base_byte >> 3);
    assign base_bank = base_byte[2:0];
    assign wr_bank   = count_reg[2:0];
    assign wr_row    = ROW_W'(count_reg >> 3);

    genvar gb;
    generate
        for (gb = 0; gb < 8; gb++)
        begin : g_bank
            logic [7:0]      mem [ROWS];
            logic [RA_W-1:0] rd_row;

            assign rd_row = base_row + ((3'(gb) < base_bank) ? RA_W'(1) : RA_W'(0));

            always_ff @(posedge clk)
            begin
                if (wr_en && (wr_bank == 3'(gb)))
                begin
                    mem[wr_row] <= item_reg.data_byte;
                end
                // rows past the end hold no stored byte and are masked later
                if (cmd.capture && (rd_row < RA_W'(ROWS)))
                begin
                    bank_q[gb] <= mem[rd_row[ROW_W-1:0]];
                end
            end
        end
    endgenerate

    // ---------------- field extraction
    logic [BIT_W-1:0] total_bits;
    logic [BIT_W-1:0] rem_bits;
    logic [WW-1:0]    n_w;
    logic [WW-1:0]    rem_w;
    logic [WW-1:0]    pos_w;
    logic             n_ok;
    logic             over;
    logic [5:0]       avail;
    logic [39:0]      window;
    logic [39:0]      window_sh;
    logic [31:0]      fetch;

    assign total_bits = {count_reg, 3'b000};
    assign rem_bits   = total_bits - pos_reg;
    assign n_w        = WW'(item_reg.bit_count);
    assign rem_w      = WW'(rem_bits);
    assign pos_w      = WW'(pos_reg);
    assign n_ok       = (item_reg.bit_count != 16'd0) &&
                        (item_reg.bit_count <= 16'(MAX_FETCH));
    assign over       = (n_w > rem_w);
    // near the end only the bits left are fetched
    assign avail      = (n_w < rem_w) ? item_reg.bit_count[5:0] : rem_bits[5:0];

    assign window = {bank_q[base_bank],
                     bank_q[base_bank + 3'd1],
                     bank_q[base_bank + 3'd2],
                     bank_q[base_bank + 3'd3],
                     bank_q[base_bank + 3'd4]};
    assign window_sh = window << pos_reg[2:0];
    assign fetch     = (n_ok && (avail != 6'd0)) ?
                       (window_sh[39:8] >> (6'd32 - avail)) : 32'd0;

    // lowest set bit of the appended byte
    logic [2:0] low_bit;
    always_comb
    begin
        low_bit = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (item_reg.data_byte[i])
            begin
                low_bit = 3'(i);
            end
        end
    end

    // ---------------- operation
    logic             full;
    logic [1:0]       status;
    logic [31:0]      value;
    logic [BIT_W-1:0] rem_after;
    logic             trailing;

    assign full = (count_reg == CNT_W'(BUFFER_BYTES));

    always_comb
    begin
        count_next    = count_reg;
        pos_next      = pos_reg;
        lo_pos_next   = lo_pos_reg;
        lo_valid_next = lo_valid_reg;
        status        = STAT_OK;
        value         = 32'd0;
        wr_en         = 1'b0;
        case (item_reg.op)
            OP_CLEAR:
            begin
                count_next    = '0;
                pos_next      = '0;
                lo_pos_next   = '0;
                lo_valid_next = 1'b0;
            end
            OP_APPEND:
            begin
                if (full)
                begin
                    status = STAT_FULL;
                end
                else
                begin
                    wr_en      = cmd.commit;
                    count_next = count_reg + CNT_W'(1);
                    if (item_reg.data_byte != 8'd0)
                    begin
                        // byte index * 8 + (7 - low bit)
                        lo_pos_next   = LO_W'({count_reg, ~low_bit});
                        lo_valid_next = 1'b1;
                    end
                end
            end
            OP_PEEK:
            begin
                value = fetch;
            end
            OP_READ:
            begin
                value = fetch;
                if (over)
                begin
                    status = STAT_OVERRUN;
                end
                else
                begin
                    pos_next = BIT_W'(pos_w + n_w);
                end
            end
            OP_SKIP:
            begin
                if (over)
                begin
                    status = STAT_OVERRUN;
                end
                else
                begin
                    pos_next = BIT_W'(pos_w + n_w);
                end
            end
            OP_REWIND:
            begin
                pos_next = (n_w > pos_w) ? '0 : BIT_W'(pos_w - n_w);
            end
            default:
            begin
                status = STAT_OK;
            end
        endcase
    end

    assign rem_after = {count_next, 3'b000} - pos_next;
    assign trailing  = (rem_after != '0) && lo_valid_next &&
                       (BIT_W'(lo_pos_next) == pos_next);

    always_comb
    begin
        rsp_next.value          = value;
        rsp_next.bits_remaining = 16'(rem_after);
        rsp_next.bits_consumed  = 16'(pos_next);
        rsp_next.byte_aligned   = (pos_next[2:0] == 3'd0);
        rsp_next.trailing_only  = trailing;
        rsp_next.more_data      = (rem_after != '0) && !trailing;
        rsp_next.status         = status;
    end

    // ---------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            pos_reg      <= '0;
            lo_pos_reg   <= '0;
            lo_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            count_reg    <= count_next;
            pos_reg      <= pos_next;
            lo_pos_reg   <= lo_pos_next;
            lo_valid_reg <= lo_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= req;
        end
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

### rtl/bitstream_reader_top.sv
// bitstream_reader_top: msb-first bitstream reader over a banked byte store
// response: a taken request is committed into the output register, held back only
//   while a stalled response still holds the output register
// flow: no new request is taken until the last one commits; the edge that takes
//   a request reads all eight store banks for the five-byte window, then it commits
// reset: count, position and last-one tracking clear, store content undefined

module bitstream_reader_top
    import bsr_pkg::*;
#(
    parameter int BUFFER_BYTES = 4096
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  bsr_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output bsr_rsp_t rsp
);

    bsr_cmd_t cmd;

    bsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd)
    );

    bsr_datapath #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

### rtl/bsr_checker.sv
// bsr_checker: port-level assertions for the bitstream reader, bound
// to the top level
// depends on bsr_pkg

module bsr_checker
    import bsr_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_ready,
    input bsr_req_t req,
    input logic     rsp_valid,
    input logic     rsp_ready,
    input bsr_rsp_t rsp
);

    // a stalled response holds its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // one request in flight: no new request the cycle after one is taken
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while one is in flight");

    a_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.byte_aligned == (rsp.bits_consumed[2:0] == 3'd0))
        else $error("byte_aligned disagrees with position");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.trailing_only && rsp.more_data) &&
                      (rsp.status != 2'd3))
        else $error("inconsistent response flags");

endmodule

bind bitstream_reader_top bsr_checker u_bsr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

### dv/bitstream_reader_top_tb.sv
`timescale 1ns / 100ps
// bitstream_reader_top_tb: self-checking bench for the msb-first bitstream reader
// keeps a shadow byte store and reader position to predict every response
// depends on bsr_pkg and bitstream_reader_top

module bitstream_reader_top_tb;
    import bsr_pkg::*;

    localparam int BUFFER_BYTES = 4096;
    localparam int STORE_BITS   = BUFFER_BYTES * 8;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PHASE_ITEMS  = 340;
    localparam int HOLD_CYCLES  = 300;
    localparam int FILL_BYTES   = 96;

    // op codes the block treats as no-ops
    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;

    typedef struct {
        bsr_req_t req;
        bit       typed;
        bsr_rsp_t rsp;
    } dir_row_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_ready;
    bsr_req_t req = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    bsr_rsp_t rsp;

    // shadow copy of the reader state
    logic [7:0]  shadow_bytes [BUFFER_BYTES];
    int unsigned shadow_count;
    int unsigned shadow_pos;
    int unsigned shadow_last_one;
    bit          shadow_last_valid;

    bsr_rsp_t    pending_rsp [$];
    dir_row_t    dir_rows [$];
    int          error_count;
    int          items_sent;
    int          cycle_count;
    int          send_idle_pct;
    int          rsp_stall_pct;
    int          hold_trigger;
    int          hold_seen;
    int          hold_left;

    bitstream_reader_top #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("bitstream_reader_top test failed");
            $finish;
        end
    end

    task automatic report_error(input string msg);
        error_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_error($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    function automatic int unsigned shadow_remaining();
        return (shadow_pos < shadow_count * 8) ? (shadow_count * 8 - shadow_pos) : 0;
    endfunction

    function automatic logic [31:0] fetch_shadow_bits(input int unsigned n);
        logic [31:0] acc;
        int unsigned i;
        int unsigned idx;
        acc = '0;
        if (n >= 1 && n <= MAX_FETCH)
        begin
            for (i = 0; i < n && shadow_pos + i < shadow_count * 8; i++)
            begin
                idx = shadow_pos + i;
                acc = {acc[30:0], shadow_bytes[idx >> 3][7 - (idx & 7)]};
            end
        end
        return acc;
    endfunction

    function automatic logic [1:0] advance_shadow(input int unsigned n);
        if (n > shadow_remaining())
            return STAT_OVERRUN;
        shadow_pos += n;
        return STAT_OK;
    endfunction

    // apply one request to the shadow state and build the response it causes
    function automatic bsr_rsp_t predict_reader_rsp(input bsr_req_t r);
        bsr_rsp_t    p;
        int unsigned n;
        int unsigned rem;
        int          low;
        bit          trail;
        p = '0;
        p.status = STAT_OK;
        n = r.bit_count;
        case (r.op)
            OP_CLEAR:
            begin
                shadow_count = 0;
                shadow_pos = 0;
                shadow_last_one = 0;
                shadow_last_valid = 0;
            end
            OP_APPEND:
            begin
                if (shadow_count >= BUFFER_BYTES)
                    p.status = STAT_FULL;
                else
                begin
                    shadow_bytes[shadow_count] = r.data_byte;
                    if (r.data_byte != 8'h00)
                    begin
                        low = 0;
                        while (!r.data_byte[low])
                            low++;
                        shadow_last_one = shadow_count * 8 + 7 - low;
                        shadow_last_valid = 1;
                    end
                    shadow_count++;
                end
            end
            OP_PEEK:
                p.value = fetch_shadow_bits(n);
            OP_READ:
            begin
                p.value = fetch_shadow_bits(n);
                p.status = advance_shadow(n);
            end
            OP_SKIP:
                p.status = advance_shadow(n);
            OP_REWIND:
                shadow_pos = (n > shadow_pos) ? 0 : shadow_pos - n;
            default:
                ;
        endcase
        rem = shadow_remaining();
        trail = (rem > 0) && shadow_last_valid && (shadow_last_one == shadow_pos);
        p.bits_remaining = rem[15:0];
        p.bits_consumed  = shadow_pos[15:0];
        p.byte_aligned   = (shadow_pos[2:0] == 3'd0);
        p.trailing_only  = trail;
        p.more_data      = (rem > 0) && !trail;
        return p;
    endfunction

    function automatic bsr_req_t make_req(input logic [2:0] op, input logic [7:0] d,
                                          input logic [15:0] c);
        bsr_req_t r;
        r.op = op;
        r.data_byte = d;
        r.bit_count = c;
        return r;
    endfunction

    function automatic bsr_rsp_t rsp_of(input logic [31:0] v, input logic [15:0] rem,
                                        input logic [15:0] pos, input logic aligned,
                                        input logic trail, input logic more,
                                        input logic [1:0] st);
        bsr_rsp_t p;
        p.value = v;
        p.bits_remaining = rem;
        p.bits_consumed = pos;
        p.byte_aligned = aligned;
        p.trailing_only = trail;
        p.more_data = more;
        p.status = st;
        return p;
    endfunction

    task automatic add_row(input logic [2:0] op, input logic [7:0] d, input logic [15:0] c,
                           input bit typed = 0, input bsr_rsp_t e = '0);
        dir_row_t row;
        row.req = make_req(op, d, c);
        row.typed = typed;
        row.rsp = e;
        dir_rows.push_back(row);
    endtask

    // present one request at the falling edge, return at the edge that takes it
    task automatic send_req(input bsr_req_t r, input bit use_typed = 0,
                            input bsr_rsp_t typed_rsp = '0);
        bsr_rsp_t predicted;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        predicted = predict_reader_rsp(r);
        pending_rsp.push_back(use_typed ? typed_rsp : predicted);
        req_valid <= 1'b1;
        req <= r;
        items_sent++;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    task automatic wait_rsp_drain();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // zeros and single ones are common so the trailing-bits flag toggles often
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(99);
        if (r < 35)
            return 8'h00;
        else if (r < 55)
            return 8'h01 << $urandom_range(7);
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [15:0] pick_count();
        int          r;
        int unsigned rem;
        int unsigned c;
        r = $urandom_range(99);
        rem = shadow_remaining();
        if (r < 70)
            c = $urandom_range(1, MAX_FETCH);
        else if (r < 80)
            c = $urandom_range(1) ? 0 : $urandom_range(MAX_FETCH + 1, 48);
        else if (r < 88)
            c = rem;
        else if (r < 95)
            c = rem + $urandom_range(1, 16);
        else
            c = $urandom_range(0, STORE_BITS);
        if (c > STORE_BITS)
            c = STORE_BITS;
        return c[15:0];
    endfunction

    function automatic bsr_req_t pick_reader_req();
        int r;
        r = $urandom_range(99);
        if (r < 20)
            return make_req(OP_PEEK, 8'($urandom_range(255)), pick_count());
        else if (r < 45)
            return make_req(OP_READ, 8'($urandom_range(255)), pick_count());
        else if (r < 58)
            return make_req(OP_SKIP, 8'($urandom_range(255)), pick_count());
        else if (r < 68)
            return make_req(OP_REWIND, 8'($urandom_range(255)),
                            16'($urandom_range(3) == 0 ? STORE_BITS :
                                $urandom_range(1, 64)));
        else if (r < 80)
        begin
            // land exactly on the last one bit
            if (shadow_last_valid && shadow_last_one >= shadow_pos)
                return make_req(OP_SKIP, 8'($urandom_range(255)),
                                16'(shadow_last_one - shadow_pos));
            return make_req(OP_REWIND, 8'($urandom_range(255)),
                            16'(shadow_pos - shadow_last_one));
        end
        else if (r < 96)
            return make_req(OP_APPEND, pick_byte(), 16'($urandom_range(0, STORE_BITS)));
        return make_req(OP_CLEAR, 8'($urandom_range(255)), 16'($urandom_range(0, STORE_BITS)));
    endfunction

    // fill some bytes, then read them back in random ways
    task automatic run_sequence();
        int k;
        int m;
        int j;
        if ($urandom_range(3) == 0 || shadow_count > 3000)
            send_req(make_req(OP_CLEAR, 8'($urandom_range(255)),
                              16'($urandom_range(0, 65535))));
        k = ($urandom_range(9) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 12);
        for (j = 0; j < k; j++)
            send_req(make_req(OP_APPEND, pick_byte(), 16'($urandom_range(0, STORE_BITS))));
        m = $urandom_range(4, 20);
        for (j = 0; j < m; j++)
            send_req(pick_reader_req());
    endtask

    // long append run, reads at the very end, largest counts
    task automatic run_fill_sequence();
        int j;
        send_req(make_req(OP_CLEAR, 8'h00, 16'd0));
        for (j = 0; j < FILL_BYTES; j++)
            send_req(make_req(OP_APPEND, pick_byte(), 16'd0));
        send_req(make_req(OP_APPEND, 8'hFF, 16'd0));
        send_req(make_req(OP_APPEND, 8'h01, 16'd0));
        send_req(make_req(OP_PEEK, 8'h00, 16'd32));
        // stop one bit short of the end
        send_req(make_req(OP_SKIP, 8'h00, 16'(FILL_BYTES * 8 + 15)));
        send_req(make_req(OP_PEEK, 8'h00, 16'd32));
        send_req(make_req(OP_READ, 8'h00, 16'd2));
        send_req(make_req(OP_SKIP, 8'h00, 16'd1));
        send_req(make_req(OP_SKIP, 8'h00, 16'd32767));
        send_req(make_req(OP_REWIND, 8'h00, 16'd32768));
        for (j = 0; j < 40; j++)
            send_req(pick_reader_req());
    endtask

    // response side: random stalls plus an occasional long hold-off
    always @(negedge clk)
    begin
        if (hold_seen != hold_trigger)
        begin
            hold_seen = hold_trigger;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    always @(posedge clk)
    begin : rsp_check
        bsr_rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsp.size() == 0)
                report_error($sformatf("response %h with no request pending", rsp));
            else
            begin
                want = pending_rsp.pop_front();
                compare_field("value", rsp.value, want.value);
                compare_field("bits_remaining", rsp.bits_remaining, want.bits_remaining);
                compare_field("bits_consumed", rsp.bits_consumed, want.bits_consumed);
                compare_field("byte_aligned", rsp.byte_aligned, want.byte_aligned);
                compare_field("trailing_only", rsp.trailing_only, want.trailing_only);
                compare_field("more_data", rsp.more_data, want.more_data);
                compare_field("status", rsp.status, want.status);
            end
        end
    end

    initial
    begin : stimulus
        int       phase;
        int       phase_end;
        dir_row_t row;
        shadow_count = 0;
        shadow_pos = 0;
        shadow_last_one = 0;
        shadow_last_valid = 0;
        error_count = 0;
        items_sent = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        hold_trigger = 0;
        hold_seen = 0;
        hold_left = 0;

        // empty store right after reset
        add_row(OP_PEEK,   8'h00, 16'd8,     1, rsp_of(0, 0, 0, 1, 0, 0, STAT_OK));
        add_row(OP_SKIP,   8'h00, 16'd1,     1, rsp_of(0, 0, 0, 1, 0, 0, STAT_OVERRUN));
        add_row(OP_READ,   8'hFF, 16'd0,     1, rsp_of(0, 0, 0, 1, 0, 0, STAT_OK));
        add_row(OP_REWIND, 8'h00, 16'd32768, 1, rsp_of(0, 0, 0, 1, 0, 0, STAT_OK));
        add_row(OP_SPARE6, 8'h5A, 16'd7,     1, rsp_of(0, 0, 0, 1, 0, 0, STAT_OK));
        add_row(OP_SPARE7, 8'hFF, 16'hFFFF,  1, rsp_of(0, 0, 0, 1, 0, 0, STAT_OK));
        // five bytes, last one bit at position 24
        add_row(OP_APPEND, 8'hA5, 16'd0,     1, rsp_of(0, 8, 0, 1, 0, 1, STAT_OK));
        add_row(OP_APPEND, 8'h00, 16'd0);
        add_row(OP_APPEND, 8'hFF, 16'd0);
        add_row(OP_APPEND, 8'h80, 16'd0);
        add_row(OP_APPEND, 8'h00, 16'd0);
        // counts outside 1..32 fetch nothing
        add_row(OP_PEEK,   8'h00, 16'd0,     1, rsp_of(0, 40, 0, 1, 0, 1, STAT_OK));
        add_row(OP_PEEK,   8'h00, 16'd33,    1, rsp_of(0, 40, 0, 1, 0, 1, STAT_OK));
        add_row(OP_PEEK,   8'h00, 16'd32);
        add_row(OP_READ,   8'h00, 16'd33);
        add_row(OP_PEEK,   8'h00, 16'd32);
        add_row(OP_REWIND, 8'h00, 16'd32768);
        add_row(OP_READ,   8'h00, 16'd4);
        add_row(OP_SKIP,   8'h00, 16'd20);
        add_row(OP_READ,   8'h00, 16'd1);
        add_row(OP_SKIP,   8'h00, 16'd15);
        add_row(OP_READ,   8'h00, 16'd1,     1, rsp_of(0, 0, 40, 1, 0, 0, STAT_OVERRUN));
        add_row(OP_SKIP,   8'h00, 16'd32768, 1, rsp_of(0, 0, 40, 1, 0, 0, STAT_OVERRUN));
        add_row(OP_CLEAR,  8'hFF, 16'hFFFF,  1, rsp_of(0, 0, 0, 1, 0, 0, STAT_OK));
        add_row(OP_APPEND, 8'h00, 16'd0);
        add_row(OP_PEEK,   8'h00, 16'd8);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            send_req(row.req, row.typed, row.rsp);
        end
        wait_rsp_drain();

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
                1: begin send_idle_pct = 61; rsp_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  rsp_stall_pct = 61; end
                default: begin send_idle_pct = 10; rsp_stall_pct = 10; end
            endcase
            if (phase == 0)
            begin
                run_fill_sequence();
                wait_rsp_drain();
            end
            phase_end = items_sent + PHASE_ITEMS;
            // back-pressure: keep offering requests while responses are held
            if (phase == 0 || phase == 2)
                hold_trigger++;
            while (items_sent < phase_end)
                run_sequence();
            wait_rsp_drain();
        end

        wait_rsp_drain();
        repeat (10) @(posedge clk);
        if (pending_rsp.size() != 0)
            report_error($sformatf("%0d responses never arrived", pending_rsp.size()));
        if (error_count == 0)
            $display("bitstream_reader_top test passed");
        else
            $display("bitstream_reader_top test failed");
        $finish;
    end

endmodule
